/* src/npc_pkg.sv */
package npc_pkg;

    localparam int CH_W                  = 8;
    localparam int IDX_W                 = 8;
    localparam int COUNT_W               = 9;
    localparam int SQ_W                  = 2 * CH_W;
    localparam int DIST_W                = SQ_W + 2;
    localparam int RGB_W                 = 3 * CH_W;
    localparam int DEFAULT_PALETTE_DEPTH = 256;
    localparam int INDEX_LIMIT           = 1 << IDX_W;

    // all ones is above the largest possible distance 3*255*255
    localparam logic [DIST_W-1:0] DIST_INIT = '1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] entry_index;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } npc_in_t;

    typedef struct packed {
        logic [IDX_W-1:0] closest_index;
        logic             exact_match;
    } npc_out_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } scan_tag_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sq_dist;
    } dist_beat_t;

endpackage

/* src/npc_ram.sv */
module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/npc_dist.sv */
module npc_dist (
    input  logic               clk,
    input  logic               rst_n,
    input  npc_pkg::scan_tag_t tag,
    input  npc_pkg::rgb_t      entry,
    input  npc_pkg::rgb_t      query,
    output npc_pkg::dist_beat_t beat
);
    import npc_pkg::*;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [CH_W-1:0] dr, dg, db;
    logic [SQ_W-1:0] sq_r_reg, sq_g_reg, sq_b_reg;
    scan_tag_t       tag_reg;

    assign dr = abs_diff(entry.red, query.red);
    assign dg = abs_diff(entry.green, query.green);
    assign db = abs_diff(entry.blue, query.blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_r_reg <= SQ_W'(dr) * SQ_W'(dr);
        sq_g_reg <= SQ_W'(dg) * SQ_W'(dg);
        sq_b_reg <= SQ_W'(db) * SQ_W'(db);
    end

    assign beat.valid   = tag_reg.valid;
    assign beat.idx     = tag_reg.idx;
    assign beat.sq_dist = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);

endmodule

/* src/nearest_palette_color_top.sv */
// Nearest palette color search. A load beat writes one RGB entry into the
// palette RAM and returns nothing. A query beat scans entries 0 to
// entry_count-1 (0 counts as 1; capped at the palette depth and at 256)
// through the single read port of the palette RAM, one entry per cycle, and
// returns the lowest index at the minimum squared distance plus an
// exact-match flag. A query holds the input until its result is loaded: one
// RAM read per entry plus the read, square and compare stages and the result
// load; the scan ends early on an exact match. Loads are accepted while a
// result waits on the output. Entries must be loaded before a query scans
// them; an unloaded entry returns arbitrary data.
module nearest_palette_color_top #(
    parameter int PALETTE_DEPTH = npc_pkg::DEFAULT_PALETTE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  npc_pkg::npc_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output npc_pkg::npc_out_t            out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [npc_pkg::COUNT_W-1:0]  cfg_data
);
    import npc_pkg::*;

    localparam int AW         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int SCAN_LIMIT = (PALETTE_DEPTH < INDEX_LIMIT) ? PALETTE_DEPTH : INDEX_LIMIT;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;
    rgb_t               query_reg, query_next;
    scan_tag_t          tag1_reg, tag1_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               out_valid_reg, out_valid_next;
    npc_out_t           out_data_reg, out_data_next;
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;

    logic [COUNT_W-1:0] count_sat;
    logic               in_fire;
    logic               ram_we;
    logic               ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [RGB_W-1:0]   ram_wdata;
    logic [RGB_W-1:0]   ram_rdata;
    dist_beat_t         dist_beat;
    logic               take;
    logic               better;
    logic               scan_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // palette RAM: written only while idle, read only while scanning
    assign ram_we    = in_fire && (in_data.req_type == REQ_LOAD)
                       && (32'(in_data.entry_index) < PALETTE_DEPTH);
    assign ram_waddr = AW'(in_data.entry_index);
    assign ram_wdata = {in_data.red, in_data.green, in_data.blue};
    assign ram_re    = (state_reg == ST_SCAN);
    assign ram_raddr = AW'(scan_idx_reg);

    npc_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PALETTE_DEPTH),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    npc_dist u_dist (
        .clk  (clk),
        .rst_n(rst_n),
        .tag  (tag1_reg),
        .entry(rgb_t'(ram_rdata)),
        .query(query_reg),
        .beat (dist_beat)
    );

    always_comb
    begin
        if (entry_count_reg == '0)
        begin
            count_sat = COUNT_W'(1);
        end
        else if (32'(entry_count_reg) > SCAN_LIMIT)
        begin
            count_sat = COUNT_W'(SCAN_LIMIT);
        end
        else
        begin
            count_sat = entry_count_reg;
        end
    end

    // beats still in flight after the scan ends are dropped here
    assign take      = dist_beat.valid && ((state_reg == ST_SCAN) || (state_reg == ST_WAIT));
    assign better    = (dist_beat.sq_dist < best_dist_reg);
    assign scan_done = take && ((better && (dist_beat.sq_dist == '0))
                                || (dist_beat.idx == last_idx_reg));

    always_comb
    begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        last_idx_next    = last_idx_reg;
        query_next       = query_reg;
        best_dist_next   = best_dist_reg;
        best_idx_next    = best_idx_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        entry_count_next = entry_count_reg;
        tag1_next.valid  = ram_re;
        tag1_next.idx    = scan_idx_reg;

        if (cfg_valid && cfg_ready)
        begin
            entry_count_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take && better)
        begin
            best_dist_next = dist_beat.sq_dist;
            best_idx_next  = dist_beat.idx;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_data.req_type == REQ_QUERY))
                begin
                    query_next     = '{red: in_data.red, green: in_data.green,
                                       blue: in_data.blue};
                    scan_idx_next  = '0;
                    last_idx_next  = IDX_W'(count_sat - COUNT_W'(1));
                    best_dist_next = DIST_INIT;
                    best_idx_next  = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (scan_idx_reg == last_idx_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.closest_index = best_idx_reg;
                    out_data_next.exact_match   = (best_dist_reg == '0);
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tag1_reg        <= '0;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= COUNT_W'(1);
        end
        else
        begin
            state_reg       <= state_next;
            tag1_reg        <= tag1_next;
            out_valid_reg   <= out_valid_next;
            entry_count_reg <= entry_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg  <= scan_idx_next;
        last_idx_reg  <= last_idx_next;
        query_reg     <= query_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        out_data_reg  <= out_data_next;
    end

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ram_we)
        else $error("palette write while a query is in progress");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= last_idx_reg))
        else $error("scan address past the last entry");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (best_idx_reg <= last_idx_reg))
        else $error("closest index past the last entry");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg ##1 out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised without a finished scan");

endmodule
